[hw/rtl/fpa_pkg.sv]
// Package for the fixed-point ALU: operation codes, format constants,
// the pipeline beat type and the saturation helper. No dependencies.
`default_nettype none
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW        = 32;
  // Dividend and quotient width of the divider: a magnitude shifted left.
  localparam int QW        = DW + FRAC_BITS;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MIN = 3'd4;
  localparam logic [2:0] OP_MAX = 3'd5;

  localparam logic [DW-1:0] SAT_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_NEG = {1'b1, {(DW-1){1'b0}}};

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic [2:0]        op;
    logic              neg;
    logic              a_less;
    logic              a_equal;
    logic              dz;
    logic [DW-1:0]     smp_res;
    logic              smp_ovf;
    logic [DW-1:0]     ma;
    logic [DW-1:0]     mb;
    logic [2*DW-1:0]   prod;
    logic [QW-1:0]     dvd;
    logic [DW-1:0]     rem;
    logic [QW-1:0]     quo;
  } pipe_t;

  // Saturates a sign and magnitude pair. Bit DW is the overflow flag.
  function automatic logic [DW:0] sat_mag(input logic neg, input logic [2*DW-1:0] mag);
    logic [DW-1:0] res;
    logic          ovf;
    ovf = 1'b0;
    res = mag[DW-1:0];
    if (!neg) begin
      if (|mag[2*DW-1:DW-1]) begin
        ovf = 1'b1;
        res = SAT_POS;
      end
    end else begin
      if ((|mag[2*DW-1:DW]) || (mag[DW-1] && (|mag[DW-2:0]))) begin
        ovf = 1'b1;
        res = SAT_NEG;
      end else begin
        res = ~mag[DW-1:0] + {{(DW-1){1'b0}}, 1'b1};
      end
    end
    return {ovf, res};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/fpa_front.sv]
// First stage: decode, magnitudes, compare flags, saturated add and
// subtract, min and max. Depends on fpa_pkg.
`default_nettype none
module fpa_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      in_valid,
  input  wire [2:0]                in_req_type,
  input  wire signed [31:0]        in_operand_a,
  input  wire signed [31:0]        in_operand_b,
  output logic                     valid_r,
  output fpa_pkg::pipe_t           pipe_r
);
  import fpa_pkg::*;

  pipe_t          pipe_nxt;
  logic [DW:0]    sum;
  logic [DW:0]    dif;
  logic           a_lt;

  always_comb begin
    sum  = {in_operand_a[DW-1], in_operand_a} + {in_operand_b[DW-1], in_operand_b};
    dif  = {in_operand_a[DW-1], in_operand_a} - {in_operand_b[DW-1], in_operand_b};
    a_lt = in_operand_a < in_operand_b;

    pipe_nxt         = '0;
    pipe_nxt.op      = in_req_type;
    pipe_nxt.neg     = in_operand_a[DW-1] ^ in_operand_b[DW-1];
    pipe_nxt.a_less  = a_lt;
    pipe_nxt.a_equal = in_operand_a == in_operand_b;
    pipe_nxt.dz      = (in_req_type == OP_DIV) && (in_operand_b == '0);
    pipe_nxt.ma      = in_operand_a[DW-1] ? (~in_operand_a + 32'sd1) : in_operand_a;
    pipe_nxt.mb      = in_operand_b[DW-1] ? (~in_operand_b + 32'sd1) : in_operand_b;
    pipe_nxt.dvd     = QW'(pipe_nxt.ma) << FRAC_BITS;

    case (in_req_type)
      OP_ADD: begin
        pipe_nxt.smp_ovf = sum[DW] ^ sum[DW-1];
        pipe_nxt.smp_res = pipe_nxt.smp_ovf ? (sum[DW] ? SAT_NEG : SAT_POS) : sum[DW-1:0];
      end
      OP_SUB: begin
        pipe_nxt.smp_ovf = dif[DW] ^ dif[DW-1];
        pipe_nxt.smp_res = pipe_nxt.smp_ovf ? (dif[DW] ? SAT_NEG : SAT_POS) : dif[DW-1:0];
      end
      // Equal operands give operand_b for both min and max.
      OP_MIN: pipe_nxt.smp_res = a_lt ? in_operand_a : in_operand_b;
      OP_MAX: pipe_nxt.smp_res = (in_operand_a > in_operand_b) ? in_operand_a
                                                                : in_operand_b;
      default: pipe_nxt.smp_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fpa_mul.sv]
// Multiply stage: the unsigned product of the two magnitudes.
// Depends on fpa_pkg.
`default_nettype none
module fpa_mul (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      pipe_valid,
  input  fpa_pkg::pipe_t           pipe_in,
  output logic                     valid_r,
  output fpa_pkg::pipe_t           pipe_r
);
  import fpa_pkg::*;

  pipe_t pipe_nxt;

  always_comb begin
    pipe_nxt      = pipe_in;
    pipe_nxt.prod = {{DW{1'b0}}, pipe_in.ma} * {{DW{1'b0}}, pipe_in.mb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fpa_div_step.sv]
// One restoring division step: produces one quotient bit per stage.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div_step (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      pipe_valid,
  input  fpa_pkg::pipe_t           pipe_in,
  output logic                     valid_r,
  output fpa_pkg::pipe_t           pipe_r
);
  import fpa_pkg::*;

  pipe_t       pipe_nxt;
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // The dividend shifts left each step, so its top bit is always next.
  always_comb begin
    trial = {pipe_in.rem, pipe_in.dvd[QW-1]};
    diff  = trial - {1'b0, pipe_in.mb};
    ge    = trial >= {1'b0, pipe_in.mb};

    pipe_nxt     = pipe_in;
    pipe_nxt.dvd = pipe_in.dvd << 1;
    pipe_nxt.rem = ge ? diff[DW-1:0] : trial[DW-1:0];
    pipe_nxt.quo = {pipe_in.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fpa_back.sv]
// Last stage: result select, saturation of multiply and divide, and the
// output register. Depends on fpa_pkg.
`default_nettype none
module fpa_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire                      pipe_valid,
  input  fpa_pkg::pipe_t           pipe_in,
  output logic                     out_valid_r,
  output logic signed [31:0]       out_result_value_r,
  output logic                     out_overflow_r,
  output logic                     out_divide_by_zero_r,
  output logic                     out_a_less_r,
  output logic                     out_a_equal_r
);
  import fpa_pkg::*;

  logic [DW:0]   mul_sat;
  logic [DW:0]   div_sat;
  logic [DW-1:0] res_nxt;
  logic          ovf_nxt;

  always_comb begin
    mul_sat = sat_mag(pipe_in.neg, pipe_in.prod >> FRAC_BITS);
    div_sat = sat_mag(pipe_in.neg, (2*DW)'(pipe_in.quo));
    res_nxt = '0;
    ovf_nxt = 1'b0;
    case (pipe_in.op)
      OP_ADD, OP_SUB, OP_MIN, OP_MAX: begin
        res_nxt = pipe_in.smp_res;
        ovf_nxt = pipe_in.smp_ovf;
      end
      OP_MUL: begin
        res_nxt = mul_sat[DW-1:0];
        ovf_nxt = mul_sat[DW];
      end
      OP_DIV: begin
        if (!pipe_in.dz) begin
          res_nxt = div_sat[DW-1:0];
          ovf_nxt = div_sat[DW];
        end
      end
      default: begin
        res_nxt = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_value_r   <= res_nxt;
      out_overflow_r       <= ovf_nxt;
      out_divide_by_zero_r <= pipe_in.dz;
      out_a_less_r         <= pipe_in.a_less;
      out_a_equal_r        <= pipe_in.a_equal;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fixed_point_alu.sv]
// Top level of the fixed-point ALU: front stage, multiplier, divider
// chain and output stage. Depends on fpa_pkg and all fpa_ stage modules.
//
// Usage: signed Q(32-FRAC_BITS).FRAC_BITS ALU, Q24.8 as built.
// Input channel: in_valid / in_stall with in_req_type, in_operand_a and
// in_operand_b; a beat is taken on a rising edge with valid high and stall
// low. Result channel: out_valid / out_stall with the result value and
// overflow, divide_by_zero, a_less and a_equal flags, one beat per item,
// in order.
// Throughput: one item per cycle while no held result stalls the pipeline.
// Every item passes through the restoring divider, one quotient bit per
// stage; add, subtract, min and max take the same path so results stay
// in order.
// Reset (rst_n low, synchronous) empties every stage; out_valid is low
// after reset. When the receiver stalls a valid result, the whole pipeline
// holds and in_stall goes high, so no beat is lost or repeated; a result
// waiting in the output register does not block the pipeline once taken.
`default_nettype none
module fixed_point_alu (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_req_type,
  input  wire  signed [31:0] in_operand_a,
  input  wire  signed [31:0] in_operand_b,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_overflow,
  output logic               out_divide_by_zero,
  output logic               out_a_less,
  output logic               out_a_equal
);
  import fpa_pkg::*;

  logic          en;
  logic          front_valid;
  pipe_t         front_pipe;
  logic          div_valid [0:QW];
  pipe_t         div_pipe  [0:QW];

  // Everything advances unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .valid_r      (front_valid),
    .pipe_r       (front_pipe)
  );

  fpa_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .pipe_valid (front_valid),
    .pipe_in    (front_pipe),
    .valid_r    (div_valid[0]),
    .pipe_r     (div_pipe[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step u_step (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .pipe_valid (div_valid[i]),
      .pipe_in    (div_pipe[i]),
      .valid_r    (div_valid[i+1]),
      .pipe_r     (div_pipe[i+1])
    );
  end

  fpa_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .en                   (en),
    .pipe_valid           (div_valid[QW]),
    .pipe_in              (div_pipe[QW]),
    .out_valid_r          (out_valid),
    .out_result_value_r   (out_result_value),
    .out_overflow_r       (out_overflow),
    .out_divide_by_zero_r (out_divide_by_zero),
    .out_a_less_r         (out_a_less),
    .out_a_equal_r        (out_a_equal)
  );

endmodule
`default_nettype wire

[hw/rtl/fpa_checker.sv]
// Port-level checks for the fixed-point ALU, bound to its top level.
// Depends on fixed_point_alu.
`default_nettype none
module fpa_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_stall,
  input  wire        out_valid,
  input  wire        out_stall,
  input  wire [31:0] out_result_value,
  input  wire        out_overflow,
  input  wire        out_divide_by_zero,
  input  wire        out_a_less,
  input  wire        out_a_equal
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a held result");

  a_dz_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result_value == 32'd0 && !out_overflow))
    else $error("divide by zero beat with nonzero result or overflow");

  a_cmp_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_a_less && out_a_equal))
    else $error("less and equal flags both set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_value)))
    else $error("stalled result beat changed");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_value   (out_result_value),
  .out_overflow       (out_overflow),
  .out_divide_by_zero (out_divide_by_zero),
  .out_a_less         (out_a_less),
  .out_a_equal        (out_a_equal)
);
`default_nettype wire
